// ===== rtl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue insert unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DUMP   = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_ENTRY    = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_op_t op;
    logic     occupied;  // cell index below occupancy
    logic     at_occ;    // cell index equals occupancy (first free slot)
    logic     is_tail;   // last occupied cell, wraps head on rotate
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: operation code plus the pair to insert.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] item_value;
  logic        [7:0]  item_priority;

  modport source (output valid, func, item_value, item_priority, input ready);
  modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_out_if
// Response channel: status kind, dumped entry and last marker.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] out_value;
  logic        [7:0]  out_priority;
  logic               last;

  modport source (output valid, kind, out_value, out_priority, last, input ready);
  modport sink   (input valid, kind, out_value, out_priority, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares against the new
// priority, and takes from its neighbor on insert shift or dump rotate.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire               clk,
  input  wire cell_ctrl_t   ctrl,
  input  wire entry_t       new_entry,
  input  wire entry_t       prev_entry,
  input  wire               prev_greater,
  input  wire entry_t       next_entry,
  input  wire entry_t       head_entry,
  output entry_t            entry,
  output logic              greater
);

  entry_t entry_next;

  // new item outranks this stored entry
  assign greater = ctrl.occupied && (new_entry.prio > entry.prio);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      CELL_INSERT: begin
        if (prev_greater) begin
          entry_next = prev_entry;
        end else if (greater || ctrl.at_occ) begin
          entry_next = new_entry;
        end
      end
      CELL_ROTATE: begin
        entry_next = ctrl.is_tail ? head_entry : next_entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_insert_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_insert_unit
// Sorted priority queue built as a chain of cells, insert and dump.
// ----------------------------------------------------------------------------
// Output: the result of a request beat is written into the output register
//   on the clock edge that takes the beat.
// Flow: an insert or an empty dump is complete when its beat is taken; a dump
//   emits one entry per cycle from the head cell while the ring rotates, as
//   long as rsp is not stalled. Requests are held off until a dump has finished.
// Reset: synchronous, clears occupancy, sequencer and output valid; cell
//   contents stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_priority_queue_insert_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire     clk,
  input  wire     rst,
  spq_in_if.sink  req,
  spq_out_if.source rsp
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t             state;
  logic [OCC_W-1:0]   occ;
  logic [IDX_W-1:0]   cnt;      // index of the entry being emitted in a dump

  logic               rsp_valid;
  kind_t              rsp_kind;
  entry_t             rsp_entry;
  logic               rsp_last;

  entry_t             entries [DEPTH];
  logic [DEPTH-1:0]   greater;
  cell_ctrl_t         ctrl    [DEPTH];

  logic               load;
  logic               accept;
  logic               full;
  logic               ins_go;
  logic               dump_first;
  logic               dump_step;
  logic               dump_last;
  cell_op_t           op;
  entry_t             new_entry;

  // output register is free when empty or being drained this cycle
  assign load   = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && load;
  assign accept = req.valid && req.ready;

  assign full       = (occ == OCC_W'(DEPTH));
  assign ins_go     = accept && (req.func == FUNC_INSERT) && !full;
  assign dump_first = accept && (req.func == FUNC_DUMP) && (occ != '0);
  // first dumped entry leaves on the accept cycle, the rest while in ST_DUMP
  assign dump_step  = dump_first || ((state == ST_DUMP) && load);
  assign dump_last  = ((OCC_W'(cnt) + OCC_W'(1)) == occ);

  assign op = ins_go ? CELL_INSERT : (dump_step ? CELL_ROTATE : CELL_HOLD);

  assign new_entry.value = req.item_value;
  assign new_entry.prio  = req.item_priority;

  // ---- chain of cells ----
  // On insert every cell below the new one shifts back by one; on dump the
  // occupied cells rotate toward the head, the tail taking the old head, so
  // after a full pass the store is as it was.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    logic   prev_g;
    entry_t next_e;

    assign ctrl[i].op       = op;
    assign ctrl[i].occupied = (OCC_W'(i) < occ);
    assign ctrl[i].at_occ   = (OCC_W'(i) == occ);
    assign ctrl[i].is_tail  = ((OCC_W'(i) + OCC_W'(1)) == occ);

    if (i == 0) begin : g_head
      assign prev_e = entries[0];
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_g = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_e = entries[0];
    end else begin : g_mid
      assign next_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl[i]),
      .new_entry    (new_entry),
      .prev_entry   (prev_e),
      .prev_greater (prev_g),
      .next_entry   (next_e),
      .head_entry   (entries[0]),
      .entry        (entries[i]),
      .greater      (greater[i])
    );
  end

  // ---- sequencer and output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ins_go) begin
        occ <= occ + OCC_W'(1);
      end

      if (dump_step) begin
        // head entry leaves while the ring rotates by one
        rsp_valid <= 1'b1;
        rsp_kind  <= KIND_ENTRY;
        rsp_entry <= entries[0];
        rsp_last  <= dump_last;
        if (dump_last) begin
          state <= ST_IDLE;
          cnt   <= '0;
        end else begin
          state <= ST_DUMP;
          cnt   <= cnt + IDX_W'(1);
        end
      end else if (accept) begin
        // insert, refused insert or empty dump: one status beat
        rsp_valid <= 1'b1;
        rsp_last  <= 1'b1;
        rsp_entry <= '0;
        if (req.func == FUNC_INSERT) begin
          rsp_kind <= full ? KIND_FULL : KIND_INSERTED;
        end else begin
          rsp_kind <= KIND_EMPTY;
        end
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.kind         = rsp_kind;
  assign rsp.out_value    = rsp_entry.value;
  assign rsp.out_priority = rsp_entry.prio;
  assign rsp.last         = rsp_last;

endmodule

`default_nettype wire
